// ===== rtl/wsfr_pkg.sv =====
// Shared types and constants for the WebSocket frame receiver.
// No dependencies; the RTL modules refer to it by scoped names.
package wsfr_pkg;

  localparam int MsgCapacity = 4096;
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);

  // parse phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_ENDED   = 3'd5;

  // result kinds
  localparam logic [2:0] K_MSG_BYTE  = 3'd0;
  localparam logic [2:0] K_MSG_END   = 3'd1;
  localparam logic [2:0] K_MSG_DISC  = 3'd2;
  localparam logic [2:0] K_PONG_BYTE = 3'd3;
  localparam logic [2:0] K_PONG_END  = 3'd4;
  localparam logic [2:0] K_CLOSE_ECHO = 3'd5;
  localparam logic [2:0] K_CLOSE_SENT = 3'd6;

  // opcodes and header bits
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [15:0] CODE_PROTO   = 16'd1002;
  localparam logic [15:0] CODE_TOO_BIG = 16'd1009;

  // register addresses
  localparam logic [2:0] ADDR_MAX_MSG = 3'd0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] close_code;
    logic [1:0]  close_len;
    logic        suppressed;
    logic        ends_session;
  } res_t;

  // one queue entry: results of one input beat
  typedef struct packed {
    logic has2;
    res_t r0;
    res_t r1;
  } qent_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] d, logic [15:0] code,
                                  logic [1:0] clen, logic supp, logic ends);
    res_t r;
    r.kind = kind;
    r.data_byte = d;
    r.close_code = code;
    r.close_len = clen;
    r.suppressed = supp;
    r.ends_session = ends;
    return r;
  endfunction

endpackage

// ===== rtl/wsfr_if.sv =====
// Valid/ready channel interfaces for the raw byte stream and the results.
// Depends on nothing.
interface wsfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface wsfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] close_code;
  logic [1:0]  close_len;
  logic        suppressed;
  logic        ends_session;
  logic        last;
  modport source (output valid, output kind, output data_byte, output close_code,
                  output close_len, output suppressed, output ends_session,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input close_code,
                input close_len, input suppressed, input ends_session,
                input last, output ready);
endinterface

// ===== rtl/websocket_frame_receiver_top.sv =====
// Top level of the WebSocket client-stream deframer: APB register, parser,
// queue and output stage. Depends on wsfr_pkg, wsfr_if and the wsfr_* modules.
//
//   channel  dir  beat
//   strm     in   one raw stream byte
//   res      out  one result (kind, data, close info, last)
//   apb      in   register write/read (max_message_bytes at 0x0)
//
// One byte is taken per cycle while the four-entry result queue has room.
// A byte with two results holds the output for both; bytes still flow until
// the queue fills. Results pass through the queue registers before output.
// Synchronous reset clears the parser and queue; no clearing pass is needed.
module websocket_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  wsfr_byte_if.sink   strm,
  wsfr_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]     max_msg;
  logic            take, push, pop, empty, full;
  wsfr_pkg::qent_t ent, head;

  // config register
  always_ff @(posedge clk) begin
    if (rst) max_msg <= 13'd4096;
    else if (psel && penable && pwrite && paddr == wsfr_pkg::ADDR_MAX_MSG)
      max_msg <= pwdata[12:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == wsfr_pkg::ADDR_MAX_MSG) ? {19'd0, max_msg} : 32'd0;

  assign strm.ready = !full;
  assign take = strm.valid && !full;

  wsfr_front u_front (
    .clk(clk), .rst(rst), .take(take), .b(strm.stream_byte),
    .max_msg(max_msg), .push(push), .ent(ent)
  );

  wsfr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(ent), .pop(pop),
    .rdata(head), .empty(empty), .full(full)
  );

  wsfr_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop), .res(res)
  );

endmodule

// ===== rtl/wsfr_front.sv =====
// Header parser and unmasker: one byte per beat, up to two results per beat.
// Depends on wsfr_pkg.
module wsfr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         b,
  input  logic [12:0]        max_msg,
  output logic               push,
  output wsfr_pkg::qent_t    ent
);

  logic [2:0]  phase, phase_next;
  logic [7:0]  flags, flags_next;
  logic [3:0]  lbl, lbl_next;
  logic [63:0] pl, pl_next;
  logic        masked, masked_next;
  logic [31:0] key, key_next;
  logic [1:0]  kidx, kidx_next;
  logic [12:0] mc, mc_next;
  logic        disc, disc_next;
  logic        csent, csent_next;
  logic [15:0] cpay, cpay_next;
  logic [1:0]  ccnt, ccnt_next;

  logic [1:0]  n;
  wsfr_pkg::res_t r0, r1;
  logic        do_hdr, do_frame, is_ctl;
  logic [7:0]  ub;
  logic [12:0] limit;

  assign limit = (max_msg < 13'(wsfr_pkg::MsgCapacity)) ? max_msg
                                                       : 13'(wsfr_pkg::MsgCapacity);

  // next state and results of one byte
  always_comb begin
    phase_next = phase; flags_next = flags; lbl_next = lbl; pl_next = pl;
    masked_next = masked; key_next = key; kidx_next = kidx; mc_next = mc;
    disc_next = disc; csent_next = csent; cpay_next = cpay; ccnt_next = ccnt;
    n = 2'd0; r0 = '0; r1 = '0;
    do_hdr = 1'b0; do_frame = 1'b0; ub = 8'd0;
    is_ctl = flags[3];
    case (phase)
      wsfr_pkg::PH_HDR0: begin
        flags_next = b;
        phase_next = wsfr_pkg::PH_HDR1;
      end
      wsfr_pkg::PH_HDR1: begin
        masked_next = b[7];
        key_next = '0;
        kidx_next = '0;
        pl_next = '0;
        if (b[6:0] == wsfr_pkg::LEN_EXT16) begin
          lbl_next = 4'd2;
          phase_next = wsfr_pkg::PH_EXTLEN;
        end else if (b[6:0] == wsfr_pkg::LEN_EXT64) begin
          lbl_next = 4'd8;
          phase_next = wsfr_pkg::PH_EXTLEN;
        end else begin
          pl_next = 64'(b[6:0]);
          if (b[7]) phase_next = wsfr_pkg::PH_KEY;
          else do_hdr = 1'b1;
        end
      end
      wsfr_pkg::PH_EXTLEN: begin
        pl_next = {pl[55:0], b};
        lbl_next = lbl - 4'd1;
        if (lbl_next == 4'd0) begin
          if (masked) phase_next = wsfr_pkg::PH_KEY;
          else do_hdr = 1'b1;
        end
      end
      wsfr_pkg::PH_KEY: begin
        key_next = {key[23:0], b};
        kidx_next = kidx + 2'd1;
        if (kidx_next == 2'd0) do_hdr = 1'b1;
      end
      wsfr_pkg::PH_PAYLOAD: begin
        ub = b ^ (masked ? key[(5'd24 - {kidx, 3'b000}) +: 8] : 8'd0);
        kidx_next = kidx + 2'd1;
        pl_next = pl - 64'd1;
        if (is_ctl) begin
          if (flags[3:0] == wsfr_pkg::OP_PING) begin
            r0 = wsfr_pkg::mk_res(wsfr_pkg::K_PONG_BYTE, ub, '0, '0, csent, 1'b0);
            n = 2'd1;
          end else if (flags[3:0] == wsfr_pkg::OP_CLOSE && ccnt < 2'd2) begin
            cpay_next = {cpay[7:0], ub};
            ccnt_next = ccnt + 2'd1;
          end
        end else if (!disc) begin
          r0 = wsfr_pkg::mk_res(wsfr_pkg::K_MSG_BYTE, ub, '0, '0, 1'b0, 1'b0);
          n = 2'd1;
          mc_next = mc + 13'd1;
        end
        if (pl_next == 64'd0) do_frame = 1'b1;
      end
      default: ;
    endcase

    // header complete: checks on the frame
    if (do_hdr) begin
      kidx_next = '0;
      cpay_next = '0;
      ccnt_next = '0;
      if (is_ctl) begin
        if (!flags[7] || pl_next >= 64'd126) begin
          r0 = wsfr_pkg::mk_res(wsfr_pkg::K_CLOSE_SENT, '0, wsfr_pkg::CODE_PROTO, '0,
                                csent, 1'b1);
          n = 2'd1;
          csent_next = 1'b1;
          phase_next = wsfr_pkg::PH_ENDED;
        end
      end else if (!disc) begin
        if (mc > limit || pl_next > 64'(limit - mc)) begin
          r0 = wsfr_pkg::mk_res(wsfr_pkg::K_MSG_DISC, '0, '0, '0, 1'b0, 1'b0);
          r1 = wsfr_pkg::mk_res(wsfr_pkg::K_CLOSE_SENT, '0, wsfr_pkg::CODE_TOO_BIG, '0,
                                csent, 1'b0);
          n = 2'd2;
          csent_next = 1'b1;
          disc_next = 1'b1;
          mc_next = '0;
        end
      end
      if (phase_next != wsfr_pkg::PH_ENDED) begin
        if (pl_next == 64'd0) do_frame = 1'b1;
        else phase_next = wsfr_pkg::PH_PAYLOAD;
      end
    end

    // frame complete
    if (do_frame) begin
      phase_next = wsfr_pkg::PH_HDR0;
      if (is_ctl) begin
        if (flags[3:0] == wsfr_pkg::OP_CLOSE) begin
          r0 = wsfr_pkg::mk_res(wsfr_pkg::K_CLOSE_ECHO, '0, cpay_next, ccnt_next,
                                csent, 1'b1);
          n = 2'd1;
          phase_next = wsfr_pkg::PH_ENDED;
        end else if (flags[3:0] == wsfr_pkg::OP_PING) begin
          if (n == 2'd0) begin
            r0 = wsfr_pkg::mk_res(wsfr_pkg::K_PONG_END, '0, '0, '0, csent, 1'b0);
            n = 2'd1;
          end else begin
            r1 = wsfr_pkg::mk_res(wsfr_pkg::K_PONG_END, '0, '0, '0, csent, 1'b0);
            n = 2'd2;
          end
        end
      end else if (flags[7]) begin
        if (disc_next) disc_next = 1'b0;
        else if (n == 2'd0) begin
          r0 = wsfr_pkg::mk_res(wsfr_pkg::K_MSG_END, '0, '0, '0, 1'b0, 1'b0);
          n = 2'd1;
        end else begin
          r1 = wsfr_pkg::mk_res(wsfr_pkg::K_MSG_END, '0, '0, '0, 1'b0, 1'b0);
          n = 2'd2;
        end
        mc_next = '0;
      end
    end
  end

  assign push = take && (n != 2'd0);
  assign ent.has2 = (n == 2'd2);
  assign ent.r0 = r0;
  assign ent.r1 = r1;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wsfr_pkg::PH_HDR0; flags <= '0; lbl <= '0; pl <= '0;
      masked <= 1'b0; key <= '0; kidx <= '0; mc <= '0;
      disc <= 1'b0; csent <= 1'b0; cpay <= '0; ccnt <= '0;
    end else if (take) begin
      phase <= phase_next; flags <= flags_next; lbl <= lbl_next; pl <= pl_next;
      masked <= masked_next; key <= key_next; kidx <= kidx_next; mc <= mc_next;
      disc <= disc_next; csent <= csent_next; cpay <= cpay_next; ccnt <= ccnt_next;
    end
  end

endmodule

// ===== rtl/wsfr_queue.sv =====
// Short queue of per-beat result groups between parser and output stage.
// Depends on wsfr_pkg.
module wsfr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsfr_pkg::qent_t wdata,
  input  logic            pop,
  output wsfr_pkg::qent_t rdata,
  output logic            empty,
  output logic            full
);

  wsfr_pkg::qent_t mem [wsfr_pkg::QDepth];
  logic [wsfr_pkg::QPtrW-1:0] wptr, rptr;
  logic [wsfr_pkg::QPtrW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (wsfr_pkg::QPtrW + 1)'(wsfr_pkg::QDepth));
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/wsfr_back.sv =====
// Output stage: sends one or two results of a queue entry, one per beat.
// Depends on wsfr_pkg and wsfr_if.
module wsfr_back (
  input  logic            clk,
  input  logic            rst,
  input  wsfr_pkg::qent_t head,
  input  logic            empty,
  output logic            pop,
  wsfr_res_if.source      res
);

  logic           sel;
  logic           last;
  wsfr_pkg::res_t cur;

  assign cur  = sel ? head.r1 : head.r0;
  assign last = sel || !head.has2;
  assign pop  = res.valid && res.ready && last;

  assign res.valid        = !empty;
  assign res.kind         = cur.kind;
  assign res.data_byte    = cur.data_byte;
  assign res.close_code   = cur.close_code;
  assign res.close_len    = cur.close_len;
  assign res.suppressed   = cur.suppressed;
  assign res.ends_session = cur.ends_session;
  assign res.last         = last;

  // second-result select
  always_ff @(posedge clk) begin
    if (rst) sel <= 1'b0;
    else if (res.valid && res.ready) sel <= !last;
  end

endmodule

// ===== rtl/wsfr_checker.sv =====
// Port-level checks on the receiver's result channel.
// Depends on wsfr_pkg; bound to websocket_frame_receiver_top.
module wsfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_kind,
  input logic [7:0]  res_data_byte,
  input logic [1:0]  res_close_len,
  input logic        res_ends_session
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // only closes end the session
  a_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ends_session |->
      (res_kind == wsfr_pkg::K_CLOSE_ECHO || res_kind == wsfr_pkg::K_CLOSE_SENT))
    else $error("ends_session on non-close result");

  // data only on byte kinds
  a_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != wsfr_pkg::K_MSG_BYTE && res_kind != wsfr_pkg::K_PONG_BYTE
      |-> res_data_byte == 8'd0)
    else $error("data on non-byte result");

  // echo length only on close echo
  a_clen: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_close_len != 2'd0 |-> res_kind == wsfr_pkg::K_CLOSE_ECHO)
    else $error("close_len on wrong kind");

endmodule

bind websocket_frame_receiver_top wsfr_checker u_chk (
  .clk(clk), .rst(rst), .res_valid(res.valid), .res_ready(res.ready),
  .res_kind(res.kind), .res_data_byte(res.data_byte),
  .res_close_len(res.close_len), .res_ends_session(res.ends_session)
);

// ===== sim/tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the WebSocket deframer testbench: predicts results per byte.
// Depends on wsfr_pkg.
package tb_pkg;
  import wsfr_pkg::*;

  typedef struct packed {
    res_t r;
    logic last;
  } beat_t;

  class deframe_scoreboard;
    // mirrored parser state
    logic [12:0] max_msg;
    logic [2:0]  phase;
    logic [7:0]  flags;
    logic [3:0]  len_left;
    logic [63:0] pay_left;
    logic        masked;
    logic [31:0] key;
    logic [1:0]  kidx;
    logic [12:0] msg_count;
    logic        discarding;
    logic        closing_sent;
    logic [15:0] cpay;
    logic [1:0]  ccount;
    beat_t       pending[$];
    beat_t       step_res[$];
    int          mismatches;

    function new();
      max_msg = 13'd4096;
      phase = PH_HDR0; flags = '0; len_left = '0; pay_left = '0; masked = 1'b0;
      key = '0; kidx = '0; msg_count = '0; discarding = 1'b0;
      closing_sent = 1'b0; cpay = '0; ccount = '0; mismatches = 0;
    endfunction

    function bit ended();
      return phase == PH_ENDED;
    endfunction

    function void add(logic [2:0] k, logic [7:0] d, logic [15:0] c, logic [1:0] cl,
                      logic s, logic e);
      beat_t b;
      if (step_res.size() >= 2) return;
      b.r = mk_res(k, d, c, cl, s, e);
      b.last = 1'b0;
      step_res.push_back(b);
    endfunction

    function void frame_done();
      phase = PH_HDR0;
      if (flags[3]) begin
        if (flags[3:0] == OP_CLOSE) begin
          add(K_CLOSE_ECHO, 8'd0, cpay, ccount, closing_sent, 1'b1);
          phase = PH_ENDED;
        end else if (flags[3:0] == OP_PING) begin
          add(K_PONG_END, 8'd0, 16'd0, 2'd0, closing_sent, 1'b0);
        end
      end else if (flags[7]) begin
        if (discarding) discarding = 1'b0;
        else add(K_MSG_END, 8'd0, 16'd0, 2'd0, 1'b0, 1'b0);
        msg_count = '0;
      end
    endfunction

    function void header_done();
      logic [12:0] lim;
      kidx = '0; cpay = '0; ccount = '0;
      if (flags[3]) begin
        if (!flags[7] || pay_left >= 64'd126) begin
          add(K_CLOSE_SENT, 8'd0, CODE_PROTO, 2'd0, closing_sent, 1'b1);
          closing_sent = 1'b1;
          phase = PH_ENDED;
          return;
        end
      end else if (!discarding) begin
        lim = (max_msg < 13'(MsgCapacity)) ? max_msg : 13'(MsgCapacity);
        if (msg_count > lim || pay_left > 64'(lim - msg_count)) begin
          add(K_MSG_DISC, 8'd0, 16'd0, 2'd0, 1'b0, 1'b0);
          add(K_CLOSE_SENT, 8'd0, CODE_TOO_BIG, 2'd0, closing_sent, 1'b0);
          closing_sent = 1'b1;
          discarding = 1'b1;
          msg_count = '0;
        end
      end
      if (pay_left == 64'd0) frame_done();
      else phase = PH_PAYLOAD;
    endfunction

    // note an accepted stream byte and queue what it should cause
    function void note_byte(logic [7:0] b);
      logic [7:0] d;
      step_res.delete();
      d = b;
      case (phase)
        PH_HDR0: begin
          flags = b; phase = PH_HDR1;
        end
        PH_HDR1: begin
          masked = b[7]; key = '0; kidx = '0; pay_left = '0;
          if (b[6:0] == LEN_EXT16) begin
            len_left = 4'd2; phase = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            len_left = 4'd8; phase = PH_EXTLEN;
          end else begin
            pay_left = 64'(b[6:0]);
            if (masked) phase = PH_KEY;
            else header_done();
          end
        end
        PH_EXTLEN: begin
          pay_left = {pay_left[55:0], b};
          len_left = len_left - 4'd1;
          if (len_left == 4'd0) begin
            if (masked) phase = PH_KEY;
            else header_done();
          end
        end
        PH_KEY: begin
          key = {key[23:0], b};
          kidx = kidx + 2'd1;
          if (kidx == 2'd0) header_done();
        end
        PH_PAYLOAD: begin
          if (masked) d = b ^ key[8*(3-kidx) +: 8];
          kidx = kidx + 2'd1;
          pay_left = pay_left - 64'd1;
          if (flags[3]) begin
            if (flags[3:0] == OP_PING)
              add(K_PONG_BYTE, d, 16'd0, 2'd0, closing_sent, 1'b0);
            else if (flags[3:0] == OP_CLOSE && ccount < 2'd2) begin
              cpay = {cpay[7:0], d};
              ccount = ccount + 2'd1;
            end
          end else if (!discarding) begin
            add(K_MSG_BYTE, d, 16'd0, 2'd0, 1'b0, 1'b0);
            msg_count = msg_count + 13'd1;
          end
          if (pay_left == 64'd0) frame_done();
        end
        default: ;
      endcase
      if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
      foreach (step_res[i]) pending.push_back(step_res[i]);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(beat_t got);
      beat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass
endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top testbench for websocket_frame_receiver_top: frame stimulus, APB writes,
// random flow control. Depends on wsfr_pkg, wsfr_if and tb_pkg.
module tb;
  import wsfr_pkg::*;
  import tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wsfr_byte_if strm ();
  wsfr_res_if  res ();

  websocket_frame_receiver_top i_dut (
    .clk(clk), .rst(rst), .strm(strm.sink), .res(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  deframe_scoreboard sb = new();
  logic [7:0] stream_q[$];
  int  hold_off = 0;
  bit  stall_on = 0;
  int  sent = 0;

  always #1 clk = ~clk;

  initial begin
    strm.valid = 1'b0;
    strm.stream_byte = '0;
    res.ready = 1'b0;
  end

  // receiver: long hold-off when asked, otherwise random stalls when stall_on is set
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else if (stall_on) res.ready <= ($urandom_range(0, 3) != 0);
    else res.ready <= 1'b1;
  end

  // collect accepted results
  always @(posedge clk) begin
    beat_t g;
    if (!rst && res.valid && res.ready) begin
      g.r = mk_res(res.kind, res.data_byte, res.close_code, res.close_len,
                   res.suppressed, res.ends_session);
      g.last = res.last;
      sb.check_result(g);
    end
  end

  // sender: bursts and gaps, predicting each byte as it is accepted;
  // a beat on offer stays on offer until it is taken
  initial begin
    int burst;
    int gap;
    burst = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (strm.valid && strm.ready) begin
        sb.note_byte(strm.stream_byte);
        void'(stream_q.pop_front());
        sent++;
      end
      if (stream_q.size() > 0 && (burst > 0 || (strm.valid && !strm.ready))) begin
        strm.valid <= 1'b1;
        strm.stream_byte <= stream_q[0];
        if (burst > 0) burst--;
      end else begin
        strm.valid <= 1'b0;
        if (stall_on && $urandom_range(0, 2) == 0) begin
          gap = $urandom_range(1, 6);
          repeat (gap) @(posedge clk);
        end
        burst = stall_on ? $urandom_range(1, 20) : 1000;
      end
    end
  end

  task automatic apb_write(logic [12:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_MAX_MSG; pwdata <= {19'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.max_msg = v;
  endtask

  task automatic drain();
    while (stream_q.size() > 0 || strm.valid) @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // queue one client frame
  task automatic push_frame(logic fin, logic [3:0] op, int len, bit mask, int ext);
    logic [31:0] k;
    k = $urandom();
    stream_q.push_back({fin, 3'($urandom_range(0, 7)), op});
    if (ext == 2 || (ext == 0 && len > 125 && len < 65536)) begin
      stream_q.push_back({mask, LEN_EXT16});
      stream_q.push_back(len[15:8]); stream_q.push_back(len[7:0]);
    end else if (ext == 8 || len > 125) begin
      stream_q.push_back({mask, LEN_EXT64});
      repeat (4) stream_q.push_back(8'd0);
      for (int i = 3; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
    end else stream_q.push_back({mask, 7'(len)});
    if (mask) for (int i = 3; i >= 0; i--) stream_q.push_back(k[8*i +: 8]);
    repeat (len) stream_q.push_back(8'($urandom()));
  endtask

  function automatic logic [3:0] data_op();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 2));
  endfunction

  // random session: mostly well-formed frames, ending in a close frame
  task automatic random_session(int nbytes);
    int start;
    int r;
    start = sent + stream_q.size();
    while (sent + stream_q.size() - start < nbytes) begin
      r = $urandom_range(0, 19);
      if (r < 11) push_frame($urandom_range(0, 2) != 0, data_op(),
                             $urandom_range(0, 12), $urandom_range(0, 5) != 0, 0);
      else if (r < 14) push_frame(1'b1, OP_PING, $urandom_range(0, 8), 1'b1, 0);
      else if (r < 15) push_frame(1'b1, 4'($urandom_range(10, 15)),
                                  $urandom_range(0, 5), 1'b1, 0);
      else if (r < 16) push_frame(1'b1, 4'h0, $urandom_range(0, 4), 1'b1, 2);
      else if (r < 17) stream_q.push_back(8'($urandom()));
      else push_frame(1'b0, 4'h1, $urandom_range(1, 6), 1'b1, 0);
    end
    if ($urandom_range(0, 1)) push_frame(1'b1, OP_CLOSE, $urandom_range(0, 4), 1'b1, 0);
    else push_frame($urandom_range(0, 1), OP_CLOSE, 126, 1'b1, 0);
    push_frame(1'b1, 4'h1, 3, 1'b1, 0);  // ignored after session end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: limit extremes, oversize, discard skip, pong
    apb_write(13'd8191);
    push_frame(1'b1, 4'h1, 0, 1'b0, 0);
    push_frame(1'b0, 4'h2, 3, 1'b1, 2);
    push_frame(1'b1, 4'h0, 2, 1'b0, 8);
    push_frame(1'b1, OP_PING, 3, 1'b1, 0);
    push_frame(1'b1, 4'hA, 2, 1'b1, 0);
    drain();
    apb_write(13'd0);
    push_frame(1'b1, 4'h1, 0, 1'b1, 0);
    push_frame(1'b1, 4'h1, 2, 1'b1, 0);
    push_frame(1'b1, 4'h1, 1, 1'b0, 0);
    push_frame(1'b1, OP_PING, 1, 1'b1, 0);
    drain();
    // long hold-off so the queue fills and the input stalls
    apb_write(13'd4096);
    hold_off = 200;
    push_frame(1'b1, OP_PING, 30, 1'b1, 0);
    drain();
    stall_on = 1;
    apb_write(13'($urandom_range(4, 40)));
    random_session(480);
    drain();
    repeat (4) stream_q.push_back(8'hFF);
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #400000;
    $display("tb failed");
    $finish;
  end
endmodule
